// ===== src/hhc_pkg.sv =====
// Shared types and constants of the hard-stop homing calibrator.
// Used by hhc_ctrl, hhc_datapath and hardstop_homing_calibrator.
package hhc_pkg;

    localparam int MAX_JOINTS = 16;
    localparam int JOINT_W    = 4;
    localparam int DATA_W     = 32;
    localparam int RAMP_W     = 16;
    localparam int SPEED_W    = 31;
    localparam int COUNT_W    = 5;
    localparam int PROD_W     = DATA_W + RAMP_W;
    localparam int DIV_STEPS  = 32;
    localparam int ITER_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [RAMP_W-1:0]  RAMP_TICKS_RST    = 16'd1000;
    localparam logic [SPEED_W-1:0] STOP_VELOCITY_RST = 31'd66;
    localparam logic [COUNT_W-1:0] JOINT_COUNT_RST   = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_VELOCITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JOINT_COUNT   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_SETUP,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        TQ_ZERO,
        TQ_HOLD,
        TQ_RAMP
    } torque_sel_t;

    typedef struct packed {
        logic capture;
        logic mult;
        logic setup;
        logic div_step;
        logic load_out;
    } hhc_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } hhc_stat_t;

    typedef struct packed {
        logic [RAMP_W-1:0]  ramp_ticks;
        logic [SPEED_W-1:0] stop_velocity;
        logic [COUNT_W-1:0] joint_count;
    } hhc_cfg_t;

endpackage

// ===== src/hardstop_homing_calibrator.sv =====
// Hard-stop homing calibrator: configuration registers and the top level.
// Depends on hhc_pkg, hhc_ctrl and hhc_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one joint sample per request:
//   joint index, tick time, position, velocity, target torque and the
//   hard-stop-to-zero offset. The first request after reset latches the
//   start tick. Output channel (out_valid/out_ready) returns one result per
//   sample: torque command, zeroed position, joint done bit, sticky
//   all-done flag. Config channel (cfg_valid/cfg_ready) is always ready and
//   writes ramp_ticks (index 0), stop_velocity (1) or joint_count (2);
//   other indexes are ignored. Write config only while the block is idle.
//   The 32-step bit-serial ramp divider runs for every sample, and the
//   done-joint count sweeps alongside it. A new sample is taken only
//   after the last one has reached the output load. Reset clears the
//   start tick, all done bits and the all-done flag, restores the register
//   defaults, and leaves stop offsets, which count only under a done bit.
//   A stalled receiver holds the result in the output register; the block
//   still takes the next sample and parks it before the output load until
//   the register frees up.
module hardstop_homing_calibrator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hhc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hhc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [hhc_pkg::JOINT_W-1:0]          joint_index,
    input  logic [hhc_pkg::DATA_W-1:0]           tick_time,
    input  logic signed [hhc_pkg::DATA_W-1:0]    measured_position,
    input  logic signed [hhc_pkg::DATA_W-1:0]    joint_velocity,
    input  logic signed [hhc_pkg::DATA_W-1:0]    target_torque,
    input  logic signed [hhc_pkg::DATA_W-1:0]    stop_to_zero,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [hhc_pkg::DATA_W-1:0]    drive_torque,
    output logic signed [hhc_pkg::DATA_W-1:0]    zeroed_position,
    output logic                                 joint_done,
    output logic                                 all_done
);
    import hhc_pkg::*;

    hhc_cfg_t  cfg_reg;
    hhc_cmd_t  cmd;
    hhc_stat_t stat;

    assign cfg_ready = 1'b1;

    // Register file: write on a completed config request, drop unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_ticks    <= RAMP_TICKS_RST;
            cfg_reg.stop_velocity <= STOP_VELOCITY_RST;
            cfg_reg.joint_count   <= JOINT_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RAMP_TICKS:    cfg_reg.ramp_ticks    <= cfg_data[RAMP_W-1:0];
                CFG_STOP_VELOCITY: cfg_reg.stop_velocity <= cfg_data[SPEED_W-1:0];
                CFG_JOINT_COUNT:   cfg_reg.joint_count   <= cfg_data[COUNT_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Sequence each sample: capture, multiply, divider setup, divide, output.
    hhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold joint state and compute torque, zeroed position and flags.
    hhc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg               (cfg_reg),
        .joint_index       (joint_index),
        .tick_time         (tick_time),
        .measured_position (measured_position),
        .joint_velocity    (joint_velocity),
        .target_torque     (target_torque),
        .stop_to_zero      (stop_to_zero),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive_torque      (drive_torque),
        .zeroed_position   (zeroed_position),
        .joint_done        (joint_done),
        .all_done          (all_done)
    );

`ifndef SYNTHESIS
    // One sample at a time: an accepted request closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a sample was in flight");

    // A new result appears only from the output load, never from idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised outside the output load");

    // The all-done flag is sticky.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(all_done))
        else $error("all_done fell without reset");
`endif

endmodule

// ===== src/hhc_ctrl.sv =====
// Sequencing controller of the hard-stop homing calibrator.
// Depends on hhc_pkg; drives the command struct of hhc_datapath.
module hhc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hhc_pkg::hhc_stat_t stat,
    output hhc_pkg::hhc_cmd_t  cmd
);
    import hhc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:   state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_MULT:   cmd.mult     = 1'b1;
            ST_SETUP:  cmd.setup    = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_FINISH: cmd.load_out = stat.out_free;
            default:   cmd          = '0;
        endcase
    end

endmodule

// ===== src/hhc_datapath.sv =====
// Datapath of the hard-stop homing calibrator: sample capture, ramp multiply,
// bit-serial divider, joint state and output register. Depends on hhc_pkg.
module hhc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hhc_pkg::hhc_cmd_t                   cmd,
    output hhc_pkg::hhc_stat_t                  stat,
    input  hhc_pkg::hhc_cfg_t                   cfg,
    input  logic [hhc_pkg::JOINT_W-1:0]         joint_index,
    input  logic [hhc_pkg::DATA_W-1:0]          tick_time,
    input  logic signed [hhc_pkg::DATA_W-1:0]   measured_position,
    input  logic signed [hhc_pkg::DATA_W-1:0]   joint_velocity,
    input  logic signed [hhc_pkg::DATA_W-1:0]   target_torque,
    input  logic signed [hhc_pkg::DATA_W-1:0]   stop_to_zero,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hhc_pkg::DATA_W-1:0]   drive_torque,
    output logic signed [hhc_pkg::DATA_W-1:0]   zeroed_position,
    output logic                                joint_done,
    output logic                                all_done
);
    import hhc_pkg::*;

    // sample registers
    logic [JOINT_W-1:0] joint_reg;
    logic [DATA_W-1:0]  pos_reg;
    logic [DATA_W-1:0]  vel_reg;
    logic [DATA_W-1:0]  target_reg;
    logic [DATA_W-1:0]  h2z_reg;
    logic [DATA_W-1:0]  elapsed_reg;

    logic               started_reg;
    logic [DATA_W-1:0]  start_time_reg;

    // joint state; an offset counts only while its done bit is set
    logic [MAX_JOINTS-1:0] done_reg;
    logic [DATA_W-1:0]     offset_mem [MAX_JOINTS];
    logic [DATA_W-1:0]     offset_q;

    // ramp arithmetic
    logic [PROD_W-1:0]  prod_reg;
    logic               neg_reg;
    torque_sel_t        sel_reg;
    logic [RAMP_W-1:0]  rem_reg;
    logic [DATA_W-1:0]  quo_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               flag_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  torque_out_reg;
    logic [DATA_W-1:0]  zpos_out_reg;
    logic               jdone_out_reg;
    logic               all_done_out_reg;

    logic               in_ramp;
    logic [DATA_W-1:0]  tgt_mag;
    logic [DATA_W-1:0]  speed;
    logic               stopped;
    logic [PROD_W-1:0]  prod_c;
    logic [RAMP_W:0]    shifted;
    logic [RAMP_W:0]    diff;
    logic               ge;
    logic               count_hit;
    logic [DATA_W-1:0]  torque_c;
    logic [DATA_W-1:0]  zpos_c;
    logic               flag_next;

    assign in_ramp = elapsed_reg <= {{(DATA_W-RAMP_W){1'b0}}, cfg.ramp_ticks};
    assign tgt_mag = target_reg[DATA_W-1] ? (~target_reg + 1'b1) : target_reg;
    assign speed   = vel_reg[DATA_W-1] ? (~vel_reg + 1'b1) : vel_reg;
    assign stopped = speed < {1'b0, cfg.stop_velocity};
    assign prod_c  = PROD_W'(tgt_mag) * PROD_W'(elapsed_reg[RAMP_W-1:0]);

    // restoring divider, one quotient bit per step
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, cfg.ramp_ticks};
    assign ge      = shifted >= {1'b0, cfg.ramp_ticks};

    assign count_hit = !iter_reg[ITER_W-1]
                       && ({1'b0, iter_reg[JOINT_W-1:0]} < cfg.joint_count)
                       && done_reg[iter_reg[JOINT_W-1:0]];

    always_comb
    begin
        case (sel_reg)
            TQ_HOLD: torque_c = target_reg;
            TQ_RAMP: torque_c = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            default: torque_c = '0;
        endcase
    end

    assign zpos_c    = pos_reg - offset_q + h2z_reg;
    assign flag_next = flag_reg | (cnt_reg == cfg.joint_count);

    assign stat.div_last = cmd.div_step && (iter_reg == ITER_W'(DIV_STEPS - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg      <= 1'b0;
            start_time_reg   <= '0;
            done_reg         <= '0;
            flag_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            all_done_out_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture && !started_reg)
            begin
                started_reg    <= 1'b1;
                start_time_reg <= tick_time;
            end
            if (cmd.mult && !done_reg[joint_reg] && !in_ramp && stopped)
            begin
                done_reg[joint_reg] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                flag_reg         <= flag_next;
                all_done_out_reg <= flag_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stop offsets
    always_ff @(posedge clk)
    begin
        if (cmd.mult && !done_reg[joint_reg] && !in_ramp && stopped)
        begin
            offset_mem[joint_reg] <= pos_reg;
        end
        offset_q <= done_reg[joint_reg] ? offset_mem[joint_reg] : '0;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            joint_reg   <= joint_index;
            pos_reg     <= measured_position;
            vel_reg     <= joint_velocity;
            target_reg  <= target_torque;
            h2z_reg     <= stop_to_zero;
            elapsed_reg <= started_reg ? (tick_time - start_time_reg) : '0;
        end
        if (cmd.mult)
        begin
            prod_reg <= prod_c;
            neg_reg  <= target_reg[DATA_W-1];
            if (done_reg[joint_reg])
            begin
                sel_reg <= TQ_ZERO;
            end
            else if (!in_ramp)
            begin
                sel_reg <= TQ_HOLD;
            end
            else if (cfg.ramp_ticks == '0)
            begin
                sel_reg <= TQ_ZERO;
            end
            else
            begin
                sel_reg <= TQ_RAMP;
            end
        end
        if (cmd.setup)
        begin
            rem_reg  <= prod_reg[PROD_W-1:DATA_W];
            quo_reg  <= prod_reg[DATA_W-1:0];
            iter_reg <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? diff[RAMP_W-1:0] : shifted[RAMP_W-1:0];
            quo_reg  <= {quo_reg[DATA_W-2:0], ge};
            iter_reg <= iter_reg + 1'b1;
            if (count_hit)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            torque_out_reg <= torque_c;
            zpos_out_reg   <= zpos_c;
            jdone_out_reg  <= done_reg[joint_reg];
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_torque    = torque_out_reg;
    assign zeroed_position = zpos_out_reg;
    assign joint_done      = jdone_out_reg;
    assign all_done        = all_done_out_reg;

endmodule
